>>> design/aia_pkg.sv
`default_nettype none
package aia_pkg;
    localparam int CAPACITY  = 1024;
    localparam int NUM_CELLS = CAPACITY + 2;
    localparam int CW        = 11;
    localparam int IW        = 10;

    localparam logic [CW-1:0] USED_HEAD  = CW'(0);
    localparam logic [CW-1:0] SPARE_HEAD = CW'(1);
    localparam logic [CW-1:0] CELL_BASE  = CW'(2);
    localparam logic [CW-1:0] LAST_CELL  = CW'(NUM_CELLS - 1);

    typedef enum logic [2:0] {
        CMD_ALLOC  = 3'd0,
        CMD_FREE   = 3'd1,
        CMD_REJUV  = 3'd2,
        CMD_OLDEST = 3'd3,
        CMD_ISALLOC = 3'd4,
        CMD_NEXT   = 3'd5,
        CMD_REPOS  = 3'd6,
        CMD_RSVD   = 3'd7
    } t_cmd;

    typedef struct packed {
        logic [2:0]    cmd;
        logic [IW-1:0] target_index;
        logic [IW-1:0] anchor_index;
    } t_in;

    typedef struct packed {
        logic          ok;
        logic [IW-1:0] index_out;
    } t_out;

    typedef struct packed {
        logic [CW-1:0] prev;
        logic [CW-1:0] next;
    } t_link;

    typedef struct packed {
        logic          we_prev;
        logic          we_next;
        logic [CW-1:0] addr;
        logic [CW-1:0] wprev;
        logic [CW-1:0] wnext;
    } t_mem_req;
endpackage
`default_nettype wire

>>> design/aia_link_mem.sv
`default_nettype none
module aia_link_mem
    import aia_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_mem_req i_req,
    output t_link         o_rdata
);
    logic [CW-1:0] r_prev [NUM_CELLS];
    logic [CW-1:0] r_next [NUM_CELLS];
    logic [CW-1:0] r_rp;
    logic [CW-1:0] r_rn;

    always_ff @(posedge i_clk) begin
        if (i_req.we_prev) begin
            r_prev[i_req.addr] <= i_req.wprev;
        end
        if (i_req.we_next) begin
            r_next[i_req.addr] <= i_req.wnext;
        end
        r_rp <= r_prev[i_req.addr];
        r_rn <= r_next[i_req.addr];
    end

    assign o_rdata = '{prev: r_rp, next: r_rn};
endmodule
`default_nettype wire

>>> design/aged_index_allocator.sv
`default_nettype none
// One link memory port serves every read and write; a cell read goes through
// address, memory register and capture steps, then queued writes go out in order.
// Throughput: one transaction at a time; ready is low until the result leaves.
// Reset: a sweep over all NUM_CELLS cells builds the free chain in index order;
// no input is taken until it ends.
module aged_index_allocator
    import aia_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_in  i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_out      o_data
);
    typedef enum logic [8:0] {
        S_INIT  = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_RD    = 9'b000000100,
        S_WAIT  = 9'b000001000,
        S_CAP   = 9'b000010000,
        S_EXEC  = 9'b000100000,
        S_WR    = 9'b001000000,
        S_DONE  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    t_mem_req mreq;
    t_link rdata;

    // microsequence: read list addresses into slots, then write list
    logic [CW-1:0] r_c, n_c;          // init sweep cell
    t_in  r_in;
    logic [CW-1:0] r_rp [8];
    logic [CW-1:0] r_rn [8];
    logic [2:0] r_slot;
    logic r_ok, n_ok;
    logic [IW-1:0] r_idx, n_idx;

    // write queue of up to six writes
    t_mem_req r_wq [6];
    logic [2:0] r_wn, r_wi;
    t_mem_req n_wq [6];
    logic [2:0] n_wn;

    logic [CW-1:0] tc, ac;
    assign tc = {1'b0, r_in.target_index} + CELL_BASE;
    assign ac = {1'b0, r_in.anchor_index} + CELL_BASE;

    function automatic logic alloc_q(input logic [CW-1:0] p, input logic [CW-1:0] n);
        return (p != n) || (n == USED_HEAD);
    endfunction

    function automatic t_mem_req wr(input logic [CW-1:0] a, input logic wp, input logic [CW-1:0] p,
                                    input logic wn, input logic [CW-1:0] n);
        t_mem_req q;
        q.addr = a; q.we_prev = wp; q.we_next = wn; q.wprev = p; q.wnext = n;
        return q;
    endfunction

    // read plan: which cell each slot needs, depends on earlier slots
    logic [CW-1:0] rd_addr;
    logic [2:0]    rd_cnt;
    always_comb begin
        rd_addr = USED_HEAD;
        rd_cnt  = 3'd0;
        case (r_in.cmd)
            CMD_ALLOC: begin
                rd_cnt = 3'd3;
                case (r_slot)
                    3'd0: rd_addr = SPARE_HEAD;
                    3'd1: rd_addr = r_rn[0];
                    default: rd_addr = USED_HEAD;
                endcase
            end
            CMD_FREE: begin
                rd_cnt = 3'd2;
                rd_addr = (r_slot == 3'd0) ? tc : SPARE_HEAD;
            end
            CMD_REJUV: begin
                rd_cnt = 3'd2;
                rd_addr = (r_slot == 3'd0) ? tc : USED_HEAD;
            end
            CMD_OLDEST: begin
                rd_cnt = 3'd1;
                rd_addr = USED_HEAD;
            end
            CMD_ISALLOC, CMD_NEXT: begin
                rd_cnt = 3'd1;
                rd_addr = tc;
            end
            CMD_REPOS: begin
                rd_cnt = 3'd2;
                rd_addr = (r_slot == 3'd0) ? tc : ac;
            end
            default: rd_cnt = 3'd0;
        endcase
    end

    logic [CW-1:0] alloc_c;
    assign alloc_c = r_rn[0];
    logic tin;
    assign tin = 1'b1; // index field width equals capacity range

    // decide result and writes from captured reads
    always_comb begin
        logic [CW-1:0] p, n, y, f;
        n_ok = 1'b0;
        n_idx = '0;
        n_wn = 3'd0;
        for (int k = 0; k < 6; k++) n_wq[k] = '0;
        p = r_rp[0];
        n = r_rn[0];
        y = '0;
        f = '0;
        case (r_in.cmd)
            CMD_ALLOC: begin
                if (alloc_c != SPARE_HEAD && alloc_c >= CELL_BASE && alloc_c <= LAST_CELL) begin
                    y = r_rp[2];
                    f = r_rn[1];
                    n_ok = 1'b1;
                    n_idx = IW'(alloc_c - CELL_BASE);
                    // y.next may change with the head if y is the alloc head: apply in order
                    n_wq[0] = wr(SPARE_HEAD, 1'b1, f, 1'b1, f);
                    n_wq[1] = wr(alloc_c, 1'b1, y, 1'b1, USED_HEAD);
                    n_wq[2] = wr(USED_HEAD, 1'b1, alloc_c, 1'b0, '0);
                    n_wq[3] = wr(y, 1'b0, '0, 1'b1, alloc_c);
                    n_wn = 3'd4;
                end
            end
            CMD_FREE: begin
                if (tin && alloc_q(p, n)) begin
                    f = r_rn[1];
                    n_ok = 1'b1;
                    n_wq[0] = wr(p, 1'b0, '0, 1'b1, n);
                    n_wq[1] = wr(n, 1'b1, p, 1'b0, '0);
                    n_wq[2] = wr(tc, 1'b1, f, 1'b1, f);
                    n_wq[3] = wr(SPARE_HEAD, 1'b1, tc, 1'b1, tc);
                    n_wn = 3'd4;
                end
            end
            CMD_REJUV: begin
                if (tin && alloc_q(p, n)) begin
                    n_ok = 1'b1;
                    if (p != n) begin
                        // youngest after unlink: if t was youngest, it is p
                        y = (r_rp[1] == tc) ? p : r_rp[1];
                        n_wq[0] = wr(p, 1'b0, '0, 1'b1, n);
                        n_wq[1] = wr(n, 1'b1, p, 1'b0, '0);
                        n_wq[2] = wr(tc, 1'b1, y, 1'b1, USED_HEAD);
                        n_wq[3] = wr(USED_HEAD, 1'b1, tc, 1'b0, '0);
                        n_wq[4] = wr(y, 1'b0, '0, 1'b1, tc);
                        n_wn = 3'd5;
                    end
                end
            end
            CMD_OLDEST: begin
                if (n != USED_HEAD && n >= CELL_BASE) begin
                    n_ok = 1'b1;
                    n_idx = IW'(n - CELL_BASE);
                end
            end
            CMD_ISALLOC: n_ok = tin && alloc_q(p, n);
            CMD_NEXT: begin
                if (tin && alloc_q(p, n) && n != USED_HEAD && n >= CELL_BASE) begin
                    n_ok = 1'b1;
                    n_idx = IW'(n - CELL_BASE);
                end
            end
            CMD_REPOS: begin
                if (r_in.anchor_index != r_in.target_index && alloc_q(p, n)
                    && alloc_q(r_rp[1], r_rn[1])) begin
                    // anchor's next after unlinking t
                    y = (r_rn[1] == tc) ? n : r_rn[1];
                    n_ok = 1'b1;
                    n_wq[0] = wr(p, 1'b0, '0, 1'b1, n);
                    n_wq[1] = wr(n, 1'b1, p, 1'b0, '0);
                    n_wq[2] = wr(tc, 1'b1, ac, 1'b1, y);
                    n_wq[3] = wr(y, 1'b1, tc, 1'b0, '0);
                    n_wq[4] = wr(ac, 1'b0, '0, 1'b1, tc);
                    n_wn = 3'd5;
                end
            end
            default: n_ok = 1'b0;
        endcase
    end

    // memory request mux; hold the read address until the data is captured
    always_comb begin
        mreq = '0;
        case (r_state)
            S_INIT: mreq = wr(r_c, 1'b1,
                              (r_c == USED_HEAD) ? USED_HEAD :
                              (r_c == SPARE_HEAD) ? CELL_BASE :
                              (r_c == LAST_CELL) ? SPARE_HEAD : r_c + CW'(1),
                              1'b1,
                              (r_c == USED_HEAD) ? USED_HEAD :
                              (r_c == SPARE_HEAD) ? CELL_BASE :
                              (r_c == LAST_CELL) ? SPARE_HEAD : r_c + CW'(1));
            S_RD, S_WAIT: mreq.addr = rd_addr;
            S_WR:   mreq = r_wq[r_wi];
            default: mreq = '0;
        endcase
    end

    aia_link_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mreq),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        n_c = r_c;
        case (r_state)
            S_INIT: begin
                n_c = r_c + CW'(1);
                if (r_c == LAST_CELL) n_state = S_IDLE;
            end
            S_IDLE: if (i_valid) n_state = (i_data.cmd == CMD_RSVD) ? S_EXEC : S_RD;
            S_RD:   n_state = S_WAIT;
            S_WAIT: n_state = S_CAP;
            S_CAP:  n_state = (r_slot + 3'd1 >= rd_cnt) ? S_EXEC : S_RD;
            S_EXEC: n_state = (n_wn != 3'd0) ? S_WR : S_OUT;
            S_WR:   n_state = (r_wi + 3'd1 >= r_wn) ? S_OUT : S_WR;
            S_OUT:  if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_c <= '0;
            r_slot <= '0;
            r_wi <= '0;
            r_wn <= '0;
        end else begin
            r_state <= n_state;
            r_c <= n_c;
            if (r_state == S_IDLE) begin
                r_slot <= '0;
                r_wi <= '0;
            end
            if (r_state == S_CAP) r_slot <= r_slot + 3'd1;
            if (r_state == S_EXEC) r_wn <= n_wn;
            if (r_state == S_WR) r_wi <= r_wi + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) r_in <= i_data;
        if (r_state == S_CAP) begin
            r_rp[r_slot] <= rdata.prev;
            r_rn[r_slot] <= rdata.next;
        end
        if (r_state == S_EXEC) begin
            r_ok <= n_ok;
            r_idx <= n_idx;
            for (int k = 0; k < 6; k++) r_wq[k] <= n_wq[k];
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_data  = '{ok: r_ok, index_out: r_ok ? r_idx : '0};
endmodule
`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 100ps
module tb;
    import aia_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in  i_data;
    logic o_valid;
    logic i_ready;
    t_out o_data;

    aged_index_allocator DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow copy of the link store, cell number = index + 2
    logic [CW-1:0] chain_prev [NUM_CELLS];
    logic [CW-1:0] chain_next [NUM_CELLS];
    t_out          pending_results [$];
    int            fail_count;
    bit            quiet_mode;
    bit            hold_off;
    int            idle_cycles;

    function automatic bit is_live(input logic [CW-1:0] c);
        return chain_prev[c] != chain_next[c] || chain_next[c] == USED_HEAD;
    endfunction

    function automatic void detach(input logic [CW-1:0] c);
        chain_next[chain_prev[c]] = chain_next[c];
        chain_prev[chain_next[c]] = chain_prev[c];
    endfunction

    function automatic void attach_after(input logic [CW-1:0] c, input logic [CW-1:0] a);
        logic [CW-1:0] n;
        n = chain_next[a];
        chain_prev[c] = a;
        chain_next[c] = n;
        chain_prev[n] = c;
        chain_next[a] = c;
    endfunction

    function automatic void chain_reset();
        chain_prev[USED_HEAD] = USED_HEAD;
        chain_next[USED_HEAD] = USED_HEAD;
        chain_prev[SPARE_HEAD] = CELL_BASE;
        chain_next[SPARE_HEAD] = CELL_BASE;
        for (int c = CELL_BASE; c < NUM_CELLS; c++) begin
            chain_prev[c] = (c + 1 < NUM_CELLS) ? CW'(c + 1) : SPARE_HEAD;
            chain_next[c] = chain_prev[c];
        end
    endfunction

    function automatic t_out allocator_predict(input t_in req);
        t_out r;
        logic [CW-1:0] tc, ac, c, f;
        bit t_ok;
        r = '0;
        t_ok = req.target_index < CAPACITY;
        tc = CW'(req.target_index) + CELL_BASE;
        ac = CW'(req.anchor_index) + CELL_BASE;
        case (req.cmd)
            CMD_ALLOC: begin
                c = chain_next[SPARE_HEAD];
                if (c != SPARE_HEAD && c >= CELL_BASE && c < NUM_CELLS) begin
                    chain_next[SPARE_HEAD] = chain_next[c];
                    chain_prev[SPARE_HEAD] = chain_next[c];
                    attach_after(c, chain_prev[USED_HEAD]);
                    r.ok = 1'b1;
                    r.index_out = IW'(c - CELL_BASE);
                end
            end
            CMD_FREE: if (t_ok && is_live(tc)) begin
                f = chain_next[SPARE_HEAD];
                detach(tc);
                chain_next[tc] = f;
                chain_prev[tc] = f;
                chain_next[SPARE_HEAD] = tc;
                chain_prev[SPARE_HEAD] = tc;
                r.ok = 1'b1;
            end
            CMD_REJUV: if (t_ok && is_live(tc)) begin
                if (chain_next[tc] != chain_prev[tc]) begin
                    detach(tc);
                    attach_after(tc, chain_prev[USED_HEAD]);
                end
                r.ok = 1'b1;
            end
            CMD_OLDEST: begin
                c = chain_next[USED_HEAD];
                if (c != USED_HEAD && c >= CELL_BASE) begin
                    r.ok = 1'b1;
                    r.index_out = IW'(c - CELL_BASE);
                end
            end
            CMD_ISALLOC: r.ok = t_ok && is_live(tc);
            CMD_NEXT: if (t_ok && is_live(tc)) begin
                c = chain_next[tc];
                if (c != USED_HEAD && c >= CELL_BASE) begin
                    r.ok = 1'b1;
                    r.index_out = IW'(c - CELL_BASE);
                end
            end
            CMD_REPOS: if (t_ok && req.anchor_index < CAPACITY &&
                           req.anchor_index != req.target_index &&
                           is_live(tc) && is_live(ac)) begin
                detach(tc);
                attach_after(tc, ac);
                r.ok = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    // valid stays up after a transaction until the next call either idles or
    // replaces the payload, so each signal gets one assignment per edge
    task automatic send_command(input logic [2:0] cmd, input int tgt, input int anc);
        t_in req;
        int gap;
        if (!quiet_mode && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.cmd = cmd;
        req.target_index = IW'(tgt);
        req.anchor_index = IW'(anc);
        i_valid <= 1'b1;
        i_data <= req;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_results.push_back(allocator_predict(req));
    endtask

    // receiver side: random stalls, always ready in quiet mode, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_off) begin
            i_ready <= 1'b0;
        end else if (quiet_mode) begin
            i_ready <= 1'b1;
        end else if (idle_cycles > 0) begin
            idle_cycles <= idle_cycles - 1;
            i_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            idle_cycles <= $urandom_range(0, 12);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result ok=%0b index=%0d", $time,
                         o_data.ok, o_data.index_out);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (want.ok !== o_data.ok)
                    $display("%0t: ok mismatch expected %0b actual %0b", $time,
                             want.ok, o_data.ok);
                if (want.index_out !== o_data.index_out)
                    $display("%0t: index_out mismatch expected %0d actual %0d", $time,
                             want.index_out, o_data.index_out);
                if (want !== o_data) fail_count++;
            end
        end
    end

    int stuck_cycles;
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n || hold_off)
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles > 5000) begin
            $display("aged_index_allocator regression: fail");
            $finish;
        end
    end

    task automatic test_directed();
        send_command(CMD_OLDEST, 0, 0);        // nothing allocated
        send_command(CMD_FREE, 5, 0);          // free of a free index
        send_command(CMD_ALLOC, 0, 0);
        send_command(CMD_REJUV, 0, 0);         // only allocated index
        send_command(CMD_NEXT, 0, 0);          // youngest
        send_command(CMD_ALLOC, 1023, 1023);
        send_command(CMD_ALLOC, 0, 0);
        send_command(CMD_ISALLOC, 1, 0);
        send_command(CMD_ISALLOC, 1023, 0);
        send_command(CMD_NEXT, 0, 0);
        send_command(CMD_REPOS, 0, 2);
        send_command(CMD_REPOS, 1, 1);         // anchor equals target
        send_command(CMD_REPOS, 1, 900);       // free anchor
        send_command(CMD_REPOS, 900, 1);       // free target
        send_command(CMD_REJUV, 1, 0);
        send_command(CMD_OLDEST, 0, 0);
        send_command(CMD_FREE, 2, 0);
        send_command(CMD_REJUV, 2, 0);
        send_command(CMD_RSVD, 1023, 1023);    // unknown code
        send_command(CMD_ALLOC, 0, 0);
        send_command(CMD_FREE, 0, 0);
        send_command(CMD_FREE, 1, 0);
        send_command(CMD_FREE, 2, 0);
    endtask

    task automatic test_fill_full();
        // fill completely, allocate when full, try next and reposition, then free every third index
        for (int k = 0; k < CAPACITY + 3; k++) send_command(CMD_ALLOC, 0, 0);
        send_command(CMD_NEXT, 1023, 0);
        send_command(CMD_REPOS, 1023, 0);
        for (int k = 0; k < CAPACITY; k += 3) send_command(CMD_FREE, k, 0);
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int k = 0; k < 8; k++) send_command(CMD_OLDEST, 0, 0);
        join
    endtask

    function automatic int pick_index();
        if ($urandom_range(0, 19) == 0) return $urandom_range(0, 1023);
        return $urandom_range(0, 47);
    endfunction

    task automatic test_random(input int count);
        logic [2:0] cmd;
        for (int k = 0; k < count; k++) begin
            cmd = 3'($urandom_range(0, 7));
            if (cmd == CMD_RSVD && $urandom_range(0, 3) != 0) cmd = CMD_ALLOC;
            send_command(cmd, pick_index(), pick_index());
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    initial begin
        fail_count = 0;
        quiet_mode = 1'b0;
        hold_off = 1'b0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        chain_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_fill_full();
        test_random(400);
        quiet_mode = 1'b1;
        test_random(200);
        drain();
        if (fail_count == 0)
            $display("aged_index_allocator regression: pass");
        else
            $display("aged_index_allocator regression: fail");
        $finish;
    end
endmodule

>>> files.f
design/aia_pkg.sv
design/aia_link_mem.sv
design/aged_index_allocator.sv
sim/tb.sv
